/* hw/rtl/rtc_bcd_pkg.sv */
// Shared types, constants and conversion functions of the BCD clock register window.
package rtc_bcd_pkg;

    // Number of nibbles held in the time stamp latch.
    localparam int LatchDepth = 13;

    // Value returned by the control register (24-hour mode bit set).
    localparam logic [3:0] CtrlValue = 4'h4;

    // Register offsets within the window.
    localparam logic [3:0] RegSecUnits  = 4'd0;
    localparam logic [3:0] RegSecTens   = 4'd1;
    localparam logic [3:0] RegMinUnits  = 4'd2;
    localparam logic [3:0] RegMinTens   = 4'd3;
    localparam logic [3:0] RegHourUnits = 4'd4;
    localparam logic [3:0] RegHourTens  = 4'd5;
    localparam logic [3:0] RegDayUnits  = 4'd6;
    localparam logic [3:0] RegDayTens   = 4'd7;
    localparam logic [3:0] RegMonUnits  = 4'd8;
    localparam logic [3:0] RegMonTens   = 4'd9;
    localparam logic [3:0] RegYearUnits = 4'd10;
    localparam logic [3:0] RegYearTens  = 4'd11;
    localparam logic [3:0] RegWeekday   = 4'd12;
    localparam logic [3:0] RegSpareLow  = 4'd13;
    localparam logic [3:0] RegSpareHigh = 4'd14;
    localparam logic [3:0] RegCtrl      = 4'd15;

    // The latch contents as one packed vector of nibbles.
    typedef logic [LatchDepth-1:0][3:0] t_nibbles;

    // One read request as captured at the input.
    typedef struct packed {
        logic [3:0]  reg_offset;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        time_valid;
    } t_req;

    // Request after the first conversion step.
    typedef struct packed {
        logic [3:0]  reg_offset;
        logic        time_valid;
        t_nibbles    digits;
        logic [13:0] year;
        logic [13:0] yadj;
        logic [7:0]  year_q100;
        logic [7:0]  yadj_q100;
        logic [4:0]  day;
        logic [2:0]  month_off;
    } t_split;

    // Request with every latch nibble computed.
    typedef struct packed {
        logic [3:0] reg_offset;
        logic       time_valid;
        t_nibbles   digits;
    } t_digits;

    // Splits a value below 128 into {tens, units}; the quotient comes from a
    // reciprocal multiply that is exact over this range.
    function automatic logic [7:0] bcd_split(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {8'd0, value} * 15'd205;
        tens  = prod[14:11];
        units = value - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
        return {tens, units[3:0]};
    endfunction

    // Floor of value / 100, computed as (value / 4) / 25 by reciprocal multiply.
    function automatic logic [7:0] div100(input logic [13:0] value);
        logic [24:0] prod;
        prod = {13'd0, value[13:2]} * 25'd5243;
        return prod[24:17];
    endfunction

    // Month offset of the weekday formula; months outside 1..12 use zero.
    function automatic logic [2:0] weekday_offset(input logic [3:0] month);
        logic [2:0] off;
        unique case (month)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Remainder modulo 7 by summing octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [15:0] value);
        logic [5:0] fold1;
        logic [3:0] fold2;
        logic [3:0] diff;
        fold1 = {5'd0, value[15]} + {3'd0, value[14:12]} + {3'd0, value[11:9]}
              + {3'd0, value[8:6]} + {3'd0, value[5:3]} + {3'd0, value[2:0]};
        fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
        diff  = fold2 - 4'd7;
        return (fold2 >= 4'd7) ? diff[2:0] : fold2[2:0];
    endfunction

endpackage

/* hw/rtl/rtc_bcd_req_if.sv */
// Request channel of the clock register window: one register read with the current time.
interface rtc_bcd_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  reg_offset;
    logic [13:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic        time_valid;

    modport source (
        output valid, reg_offset, now_year, now_month, now_day, now_hour,
               now_minute, now_second, time_valid,
        input  ready
    );

    modport sink (
        input  valid, reg_offset, now_year, now_month, now_day, now_hour,
               now_minute, now_second, time_valid,
        output ready
    );
endinterface

/* hw/rtl/rtc_bcd_rsp_if.sv */
// Response channel of the clock register window: the nibble returned by a read.
interface rtc_bcd_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] read_nibble;

    modport source (
        output valid, read_nibble,
        input  ready
    );

    modport sink (
        input  valid, read_nibble,
        output ready
    );
endinterface

/* hw/rtl/rtc_bcd_split.sv */
// First conversion stage: BCD digits of the time fields and the year divisions.
module rtc_bcd_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rtc_bcd_pkg::t_req   i_data,
    input  logic                i_down_ready,
    output logic                o_ready,
    output logic                o_valid,
    output rtc_bcd_pkg::t_split o_data
);

    logic                r_valid;
    rtc_bcd_pkg::t_split r_data;
    rtc_bcd_pkg::t_split n_data;
    logic [7:0]          sec_bcd;
    logic [7:0]          min_bcd;
    logic [7:0]          hour_bcd;
    logic [7:0]          day_bcd;
    logic [7:0]          mon_bcd;

    // The stage takes a new request when it is empty or its content moves on.
    assign o_ready = !r_valid || i_down_ready;

    assign sec_bcd  = rtc_bcd_pkg::bcd_split({1'b0, i_data.second});
    assign min_bcd  = rtc_bcd_pkg::bcd_split({1'b0, i_data.minute});
    assign hour_bcd = rtc_bcd_pkg::bcd_split({2'd0, i_data.hour});
    assign day_bcd  = rtc_bcd_pkg::bcd_split({2'd0, i_data.day});
    assign mon_bcd  = rtc_bcd_pkg::bcd_split({3'd0, i_data.month});

    // Time digits, the weekday year (one less before March) and its centuries.
    always_comb begin
        n_data            = '0;
        n_data.reg_offset = i_data.reg_offset;
        n_data.time_valid = i_data.time_valid;
        n_data.digits[rtc_bcd_pkg::RegSecUnits]  = sec_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegSecTens]   = sec_bcd[7:4];
        n_data.digits[rtc_bcd_pkg::RegMinUnits]  = min_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegMinTens]   = min_bcd[7:4];
        n_data.digits[rtc_bcd_pkg::RegHourUnits] = hour_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegHourTens]  = hour_bcd[7:4];
        n_data.digits[rtc_bcd_pkg::RegDayUnits]  = day_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegDayTens]   = day_bcd[7:4];
        n_data.digits[rtc_bcd_pkg::RegMonUnits]  = mon_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegMonTens]   = mon_bcd[7:4];
        n_data.year = i_data.year;
        if (i_data.month < 4'd3 && i_data.year != 14'd0) begin
            n_data.yadj = i_data.year - 14'd1;
        end else begin
            n_data.yadj = i_data.year;
        end
        n_data.year_q100 = rtc_bcd_pkg::div100(i_data.year);
        n_data.yadj_q100 = rtc_bcd_pkg::div100(n_data.yadj);
        n_data.day       = i_data.day;
        n_data.month_off = rtc_bcd_pkg::weekday_offset(i_data.month);
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/rtc_bcd_weekday.sv */
// Second conversion stage: two-digit year and the weekday of the date.
module rtc_bcd_weekday (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rtc_bcd_pkg::t_split  i_data,
    input  logic                 i_down_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output rtc_bcd_pkg::t_digits o_data
);

    logic                 r_valid;
    rtc_bcd_pkg::t_digits r_data;
    rtc_bcd_pkg::t_digits n_data;
    logic [13:0]          q_ext;
    logic [13:0]          yy_wide;
    logic [7:0]           yy_bcd;
    logic [15:0]          day_sum;

    assign o_ready = !r_valid || i_down_ready;

    // Year modulo 100 as the year minus 100 times its centuries.
    assign q_ext   = {6'd0, i_data.year_q100};
    assign yy_wide = i_data.year - ((q_ext << 6) + (q_ext << 5) + (q_ext << 2));
    assign yy_bcd  = rtc_bcd_pkg::bcd_split(yy_wide[6:0]);

    // Day count y + y/4 - y/100 + y/400 + month offset + day; never negative.
    assign day_sum = {2'd0, i_data.yadj} + {4'd0, i_data.yadj[13:2]}
                   - {8'd0, i_data.yadj_q100} + {10'd0, i_data.yadj_q100[7:2]}
                   + {13'd0, i_data.month_off} + {11'd0, i_data.day};

    always_comb begin
        n_data            = '0;
        n_data.reg_offset = i_data.reg_offset;
        n_data.time_valid = i_data.time_valid;
        n_data.digits     = i_data.digits;
        n_data.digits[rtc_bcd_pkg::RegYearUnits] = yy_bcd[3:0];
        n_data.digits[rtc_bcd_pkg::RegYearTens]  = yy_bcd[7:4];
        n_data.digits[rtc_bcd_pkg::RegWeekday]   = {1'b0, rtc_bcd_pkg::mod7(day_sum)};
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/rtc_bcd_register_latch.sv */
// Top level of the read-only BCD clock register window with its time stamp latch.
//
// Each request is one read of a 16-nibble register window and carries the current
// binary date and time. A read of register 0, or any read while the latch holds no
// time stamp yet, refreshes the 13-nibble latch (BCD seconds, minutes, hours, day,
// month, two-digit year and weekday with 0 = Sunday; all zeros when the time is
// flagged invalid) before the nibble is returned, so a sweep over registers 1 to 12
// sees one consistent time. Register 15 reads 4 (24-hour mode), 13 and 14 read 0.
// The block takes one request per clock cycle unless back-pressure from the
// response side fills the pipeline. Each request passes an input register, two
// conversion registers (digit split with the year divisions, then year digits and
// weekday) and the result register, where the latch is updated in request order.
// Every stage holds its request only while the stage after it is full and holding
// its own, so stalls are absorbed stage by stage.
module rtc_bcd_register_latch (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtc_bcd_req_if.sink   i_req,
    rtc_bcd_rsp_if.source o_rsp
);

    logic                  r_req_valid;
    rtc_bcd_pkg::t_req     r_req;
    logic                  req_ready;

    logic                  split_ready;
    logic                  split_valid;
    rtc_bcd_pkg::t_split   split_data;

    logic                  wd_ready;
    logic                  wd_valid;
    rtc_bcd_pkg::t_digits  wd_data;

    logic                  out_ready;
    logic                  commit;
    logic                  refresh;
    rtc_bcd_pkg::t_nibbles fresh;
    rtc_bcd_pkg::t_nibbles n_latch;
    logic [3:0]            n_nibble;

    rtc_bcd_pkg::t_nibbles r_latch;
    logic                  r_latch_valid;
    logic                  r_out_valid;
    logic [3:0]            r_nibble;

    // Input register.
    assign req_ready   = !r_req_valid || split_ready;
    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (req_ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_ready && i_req.valid) begin
            r_req.reg_offset <= i_req.reg_offset;
            r_req.year       <= i_req.now_year;
            r_req.month      <= i_req.now_month;
            r_req.day        <= i_req.now_day;
            r_req.hour       <= i_req.now_hour;
            r_req.minute     <= i_req.now_minute;
            r_req.second     <= i_req.now_second;
            r_req.time_valid <= i_req.time_valid;
        end
    end

    // Conversion stages.
    rtc_bcd_split u_split (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_req_valid),
        .i_data       (r_req),
        .i_down_ready (wd_ready),
        .o_ready      (split_ready),
        .o_valid      (split_valid),
        .o_data       (split_data)
    );

    rtc_bcd_weekday u_weekday (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (split_valid),
        .i_data       (split_data),
        .i_down_ready (out_ready),
        .o_ready      (wd_ready),
        .o_valid      (wd_valid),
        .o_data       (wd_data)
    );

    // Latch refresh and register selection for the request leaving the pipeline.
    assign out_ready = !r_out_valid || o_rsp.ready;
    assign commit    = wd_valid && out_ready;
    assign refresh   = (wd_data.reg_offset == rtc_bcd_pkg::RegSecUnits) || !r_latch_valid;
    assign fresh     = wd_data.time_valid ? wd_data.digits : '0;
    assign n_latch   = refresh ? fresh : r_latch;

    always_comb begin
        priority if (wd_data.reg_offset < 4'(rtc_bcd_pkg::LatchDepth)) begin
            n_nibble = n_latch[wd_data.reg_offset];
        end else if (wd_data.reg_offset == rtc_bcd_pkg::RegCtrl) begin
            n_nibble = rtc_bcd_pkg::CtrlValue;
        end else begin
            n_nibble = 4'd0;
        end
    end

    // Control state of the result stage and the latch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_latch_valid <= 1'b0;
        end else begin
            if (out_ready) begin
                r_out_valid <= wd_valid;
            end
            if (commit) begin
                r_latch_valid <= 1'b1;
            end
        end
    end

    // Latch and result payload.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_latch  <= n_latch;
            r_nibble <= n_nibble;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_nibble = r_nibble;

`ifndef SYNTHESIS
    // Any request leaving the pipeline leaves a valid time stamp behind.
    a_latch_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_latch_valid)
        else $error("latch not valid after a read completed");

    // The control register always returns the 24-hour mode value.
    a_ctrl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && wd_data.reg_offset == rtc_bcd_pkg::RegCtrl)
        |=> (o_rsp.valid && o_rsp.read_nibble == rtc_bcd_pkg::CtrlValue))
        else $error("control register returned a wrong value");

    // Offsets past the latch other than the control register read zero.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (wd_data.reg_offset == rtc_bcd_pkg::RegSpareLow
                    || wd_data.reg_offset == rtc_bcd_pkg::RegSpareHigh))
        |=> (o_rsp.read_nibble == 4'd0))
        else $error("unused register returned nonzero data");

    // A stored weekday is always below seven.
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latch_valid |-> (r_latch[rtc_bcd_pkg::RegWeekday] < 4'd7))
        else $error("latched weekday out of range");

    // A read of a latch register without refresh returns the stored nibble.
    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !refresh && wd_data.reg_offset < 4'(rtc_bcd_pkg::LatchDepth))
        |=> (o_rsp.read_nibble == $past(r_latch[wd_data.reg_offset]) && $stable(r_latch)))
        else $error("read without refresh changed or missed the latch");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the BCD clock register window with its time stamp latch.
module testbench;

    // Month offsets of the weekday sum, January in the lowest slot.
    localparam logic [11:0][2:0] MonthShifts = {3'd4, 3'd2, 3'd6, 3'd4, 3'd1, 3'd5,
                                                3'd3, 3'd0, 3'd5, 3'd2, 3'd3, 3'd0};

    localparam int StuckLimit  = 2000;
    localparam int DrainCycles = 8;
    localparam int RandomReads = 700;

    // One expected response together with the offset that was read.
    typedef struct packed {
        logic [3:0] reg_offset;
        logic [3:0] nibble;
    } t_expect;

    logic i_clk;
    logic i_rst_n;

    rtc_bcd_req_if req_bus ();
    rtc_bcd_rsp_if rsp_bus ();

    rtc_bcd_register_latch i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    rtc_bcd_pkg::t_req pending_reads [$];
    t_expect           expected_nibbles [$];
    rtc_bcd_pkg::t_req offered;

    // Predicted time stamp latch.
    logic [3:0] stamp [rtc_bcd_pkg::LatchDepth];
    bit         stamp_held = 1'b0;

    int reads_sent   = 0;
    int nibbles_seen = 0;
    int error_count  = 0;
    int hold_left    = 0;
    int stuck_cycles = 0;

    // Clock with a period of 20.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Predicts the nibble of one read and refreshes the stamp where the read does.
    function automatic logic [3:0] read_window(input rtc_bcd_pkg::t_req rd);
        int yr;
        int shift;
        int yy;
        if (rd.reg_offset == rtc_bcd_pkg::RegSecUnits || !stamp_held) begin
            stamp_held = 1'b1;
            if (!rd.time_valid) begin
                foreach (stamp[i]) stamp[i] = 4'd0;
            end else begin
                // Dates before March belong to the previous year; year zero stays zero.
                yr = int'(rd.year);
                if (rd.month < 4'd3 && yr > 0) yr = yr - 1;
                shift = (rd.month >= 4'd1 && rd.month <= 4'd12) ?
                        int'(MonthShifts[int'(rd.month) - 1]) : 0;
                yy = int'(rd.year) % 100;
                stamp[rtc_bcd_pkg::RegSecUnits]  = 4'(rd.second % 10);
                stamp[rtc_bcd_pkg::RegSecTens]   = 4'(rd.second / 10);
                stamp[rtc_bcd_pkg::RegMinUnits]  = 4'(rd.minute % 10);
                stamp[rtc_bcd_pkg::RegMinTens]   = 4'(rd.minute / 10);
                stamp[rtc_bcd_pkg::RegHourUnits] = 4'(rd.hour % 10);
                stamp[rtc_bcd_pkg::RegHourTens]  = 4'(rd.hour / 10);
                stamp[rtc_bcd_pkg::RegDayUnits]  = 4'(rd.day % 10);
                stamp[rtc_bcd_pkg::RegDayTens]   = 4'(rd.day / 10);
                stamp[rtc_bcd_pkg::RegMonUnits]  = 4'(rd.month % 10);
                stamp[rtc_bcd_pkg::RegMonTens]   = 4'(rd.month / 10);
                stamp[rtc_bcd_pkg::RegYearUnits] = 4'(yy % 10);
                stamp[rtc_bcd_pkg::RegYearTens]  = 4'(yy / 10);
                stamp[rtc_bcd_pkg::RegWeekday]   = 4'((yr + yr / 4 - yr / 100 + yr / 400
                                                       + shift + int'(rd.day)) % 7);
            end
        end
        if (rd.reg_offset < rtc_bcd_pkg::LatchDepth) return stamp[rd.reg_offset];
        if (rd.reg_offset == rtc_bcd_pkg::RegCtrl) return rtc_bcd_pkg::CtrlValue;
        return 4'd0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Queues a read with a given time.
    task automatic add_read(input logic [3:0] offset, input int year, input int month,
                            input int day, input int hour, input int minute,
                            input int second, input bit good);
        rtc_bcd_pkg::t_req rd;
        rd.reg_offset = offset;
        rd.year       = 14'(year);
        rd.month      = 4'(month);
        rd.day        = 5'(day);
        rd.hour       = 5'(hour);
        rd.minute     = 6'(minute);
        rd.second     = 6'(second);
        rd.time_valid = good;
        pending_reads.push_back(rd);
    endtask

    // Queues a read with a random time; a wild one spans the full field widths.
    task automatic add_random_read(input logic [3:0] offset, input bit wild);
        if (wild) begin
            add_read(offset, $urandom_range(16383), $urandom_range(15), $urandom_range(31),
                     $urandom_range(31), $urandom_range(63), $urandom_range(63),
                     $urandom_range(1));
        end else begin
            add_read(offset, $urandom_range(9999, 1), $urandom_range(12, 1),
                     $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                     $urandom_range(59), $urandom_range(19) != 0);
        end
    endtask

    // Request driver: presents the next queued read once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_nibbles.push_back('{offered.reg_offset, read_window(offered)});
                reads_sent++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_reads.size() > 0 &&
                    ((reads_sent >= 250 && reads_sent < 450) ||
                     $urandom_range(99) >= 36)) begin
                    offered = pending_reads.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.reg_offset <= offered.reg_offset;
                    req_bus.now_year   <= offered.year;
                    req_bus.now_month  <= offered.month;
                    req_bus.now_day    <= offered.day;
                    req_bus.now_hour   <= offered.hour;
                    req_bus.now_minute <= offered.minute;
                    req_bus.now_second <= offered.second;
                    req_bus.time_valid <= offered.time_valid;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each nibble and drives ready, with one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_nibbles.size() == 0) begin
                    report_mismatch($sformatf("response %0h with no read outstanding",
                                              rsp_bus.read_nibble));
                end else begin
                    t_expect exp_item;
                    exp_item = expected_nibbles.pop_front();
                    if (rsp_bus.read_nibble !== exp_item.nibble)
                        report_mismatch($sformatf("offset %0d read_nibble %0h, expected %0h",
                                                  exp_item.reg_offset, rsp_bus.read_nibble,
                                                  exp_item.nibble));
                end
                nibbles_seen++;
                if (nibbles_seen == 260) hold_left = 70;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (nibbles_seen >= 250 && nibbles_seen < 450) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == StuckLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int sweep_len;
        bit shuffled;
        int total_reads;
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.reg_offset = '0;
        req_bus.now_year   = '0;
        req_bus.now_month  = '0;
        req_bus.now_day    = '0;
        req_bus.now_hour   = '0;
        req_bus.now_minute = '0;
        req_bus.now_second = '0;
        req_bus.time_valid = 1'b0;
        rsp_bus.ready      = 1'b0;

        // First read is not register 0, so the empty latch must refresh anyway.
        add_read(rtc_bcd_pkg::RegHourTens, 2024, 2, 29, 23, 59, 58, 1'b1);
        // The stamp holds although the time has moved on.
        add_read(rtc_bcd_pkg::RegWeekday, 1999, 7, 4, 1, 2, 3, 1'b1);
        // An invalid time clears the stamp.
        add_read(rtc_bcd_pkg::RegSecUnits, 2024, 5, 17, 12, 34, 56, 1'b0);
        add_read(rtc_bcd_pkg::RegWeekday, 2024, 5, 17, 12, 34, 56, 1'b1);
        add_read(rtc_bcd_pkg::RegCtrl, 16383, 15, 31, 31, 63, 63, 1'b1);
        add_read(rtc_bcd_pkg::RegSpareLow, 16383, 15, 31, 31, 63, 63, 1'b1);
        add_read(rtc_bcd_pkg::RegSpareHigh, 16383, 15, 31, 31, 63, 63, 1'b1);
        // All fields at their widest, month past December.
        add_read(rtc_bcd_pkg::RegSecUnits, 16383, 15, 31, 31, 63, 63, 1'b1);
        add_read(rtc_bcd_pkg::RegSecTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegMinTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegHourTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegDayTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegMonTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegYearTens, 0, 0, 0, 0, 0, 0, 1'b0);
        add_read(rtc_bcd_pkg::RegWeekday, 0, 0, 0, 0, 0, 0, 1'b0);
        // Year zero in January: the decremented year stays at zero.
        add_read(rtc_bcd_pkg::RegSecUnits, 0, 1, 1, 0, 0, 0, 1'b1);
        add_read(rtc_bcd_pkg::RegWeekday, 5000, 6, 6, 6, 6, 6, 1'b1);
        // All-zero time with month zero.
        add_read(rtc_bcd_pkg::RegSecUnits, 0, 0, 0, 0, 0, 0, 1'b1);
        add_read(rtc_bcd_pkg::RegWeekday, 1, 1, 1, 1, 1, 1, 1'b1);
        add_read(rtc_bcd_pkg::RegMonTens, 1, 1, 1, 1, 1, 1, 1'b1);
        // Month 13 counts as after February.
        add_read(rtc_bcd_pkg::RegSecUnits, 2000, 13, 9, 8, 7, 6, 1'b1);
        add_read(rtc_bcd_pkg::RegWeekday, 2001, 3, 3, 3, 3, 3, 1'b1);
        add_read(rtc_bcd_pkg::RegMonUnits, 2001, 3, 3, 3, 3, 3, 1'b1);

        // Mostly sweeps that start at register 0, the rest single random reads.
        while (pending_reads.size() < RandomReads) begin
            if ($urandom_range(99) < 70) begin
                sweep_len = $urandom_range(16, 2);
                shuffled  = $urandom_range(1);
                add_random_read(rtc_bcd_pkg::RegSecUnits, $urandom_range(99) < 10);
                for (int k = 1; k < sweep_len; k++)
                    add_random_read(shuffled ? 4'($urandom_range(15, 1)) : 4'(k),
                                    $urandom_range(99) < 10);
            end else begin
                add_random_read(4'($urandom_range(15)), $urandom_range(99) < 30);
            end
        end
        total_reads = pending_reads.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every queued read has come back as a response.
        while (nibbles_seen < total_reads)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rtc_bcd_pkg.sv
hw/rtl/rtc_bcd_req_if.sv
hw/rtl/rtc_bcd_rsp_if.sv
hw/rtl/rtc_bcd_split.sv
hw/rtl/rtc_bcd_weekday.sv
hw/rtl/rtc_bcd_register_latch.sv
sim/testbench.sv
